// ===== rtl/lorenz_teleprinter_cipher_macros.svh =====
`ifndef LORENZ_TELEPRINTER_CIPHER_MACROS_SVH
`define LORENZ_TELEPRINTER_CIPHER_MACROS_SVH

// same-cycle implication on the block clock, masked during reset
`define LTC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ltc assertion failed");

// next-cycle implication on the block clock, masked during reset
`define LTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ltc assertion failed");

`endif

// ===== rtl/ltc_pkg.sv =====
package ltc_pkg;

    typedef logic [4:0] t_code;
    typedef logic [7:0] t_char;

    typedef struct packed {
        t_code cipher_code;
        t_code key_code;
        t_code plain_code;
    } t_result;

    localparam int unsigned NUM_WHEELS = 5;

    localparam int unsigned CHI_LEN0 = 41;
    localparam int unsigned CHI_LEN1 = 31;
    localparam int unsigned CHI_LEN2 = 29;
    localparam int unsigned CHI_LEN3 = 26;
    localparam int unsigned CHI_LEN4 = 23;
    localparam int unsigned PSI_LEN0 = 43;
    localparam int unsigned PSI_LEN1 = 47;
    localparam int unsigned PSI_LEN2 = 51;
    localparam int unsigned PSI_LEN3 = 53;
    localparam int unsigned PSI_LEN4 = 59;
    localparam int unsigned MOTOR1_LEN = 61;
    localparam int unsigned MOTOR2_LEN = 37;

    // pattern bit p sits at index p, leftmost bit first
    localparam logic [0:CHI_LEN0-1] CHI_PAT0 =
        41'b11111_00010_10110_00111_10001_01110_10001_00011_1;
    localparam logic [0:CHI_LEN1-1] CHI_PAT1 =
        31'b11000_01101_01110_11010_11011_00100_0;
    localparam logic [0:CHI_LEN2-1] CHI_PAT2 =
        29'b10001_00111_10011_00011_10111_1010;
    localparam logic [0:CHI_LEN3-1] CHI_PAT3 =
        26'b11110_00110_10001_00011_10100_1;
    localparam logic [0:CHI_LEN4-1] CHI_PAT4 =
        23'b11011_11000_00010_10001_110;

    localparam logic [0:PSI_LEN0-1] PSI_PAT0 =
        43'b10110_00110_10010_10011_01010_10101_01101_01010_100;
    localparam logic [0:PSI_LEN1-1] PSI_PAT1 =
        47'b11010_10101_01010_11101_10101_01010_11000_10101_01011_10;
    localparam logic [0:PSI_LEN2-1] PSI_PAT2 =
        51'b10100_00100_11010_10101_01000_10110_10111_01010_10100_10100_1;
    localparam logic [0:PSI_LEN3-1] PSI_PAT3 =
        53'b01010_11010_10100_00101_01001_10110_10100_11011_01011_01011_001;
    localparam logic [0:PSI_LEN4-1] PSI_PAT4 =
        59'b01010_10101_01010_10110_10100_10011_01010_01001_01010_10010_00100_1010;

    localparam logic [0:MOTOR1_LEN-1] MOTOR1_PAT =
        61'b01011_11110_11010_11001_00011_10111_10001_00100_11100_01111_10101_11010_0;
    localparam logic [0:MOTOR2_LEN-1] MOTOR2_PAT =
        37'b01110_11100_01111_11111_00001_01011_11111_11;

    // teleprinter code of a character byte, case folded, aliases share an arm
    function automatic t_code code_of(input t_char c);
        t_code code;
        case (c) inside
            8'h61, 8'h41, 8'h2D: code = 5'd3;
            8'h62, 8'h42, 8'h3F: code = 5'd25;
            8'h63, 8'h43, 8'h3A: code = 5'd14;
            8'h64, 8'h44:        code = 5'd9;
            8'h65, 8'h45, 8'h33: code = 5'd1;
            8'h66, 8'h46, 8'h21: code = 5'd13;
            8'h67, 8'h47, 8'h26: code = 5'd26;
            8'h68, 8'h48:        code = 5'd20;
            8'h69, 8'h49, 8'h38: code = 5'd6;
            8'h6A, 8'h4A:        code = 5'd11;
            8'h6B, 8'h4B, 8'h28: code = 5'd15;
            8'h6C, 8'h4C, 8'h29: code = 5'd18;
            8'h6D, 8'h4D, 8'h2E: code = 5'd28;
            8'h6E, 8'h4E, 8'h2C: code = 5'd12;
            8'h6F, 8'h4F, 8'h39: code = 5'd24;
            8'h70, 8'h50, 8'h30: code = 5'd22;
            8'h71, 8'h51, 8'h31: code = 5'd23;
            8'h72, 8'h52, 8'h34: code = 5'd10;
            8'h73, 8'h53, 8'h27: code = 5'd5;
            8'h74, 8'h54, 8'h35: code = 5'd16;
            8'h75, 8'h55, 8'h37: code = 5'd7;
            8'h76, 8'h56, 8'h3D: code = 5'd30;
            8'h77, 8'h57, 8'h32: code = 5'd19;
            8'h78, 8'h58, 8'h2F: code = 5'd29;
            8'h79, 8'h59, 8'h36: code = 5'd21;
            8'h7A, 8'h5A, 8'h2B: code = 5'd17;
            8'h20:               code = 5'd4;
            8'h0A:               code = 5'd2;
            default:             code = 5'd0;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/ltc_wheel.sv =====
module ltc_wheel #(
    parameter int unsigned LEN = 2,
    parameter logic [0:LEN-1] PAT = '0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    output logic o_bit,
    output logic o_next_bit
);

    localparam int unsigned W = (LEN > 1) ? $clog2(LEN) : 1;

    logic [W-1:0] r_pos;
    logic [W-1:0] n_pos;

    assign n_pos      = (r_pos == W'(LEN - 1)) ? '0 : r_pos + W'(1);
    assign o_bit      = PAT[r_pos];
    assign o_next_bit = PAT[n_pos];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== rtl/ltc_keystream.sv =====
module ltc_keystream (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    output ltc_pkg::t_code o_key
);

    logic [ltc_pkg::NUM_WHEELS-1:0] chi_bit;
    logic [ltc_pkg::NUM_WHEELS-1:0] psi_bit;
    logic [ltc_pkg::NUM_WHEELS-1:0] chi_nxt_unused;
    logic [ltc_pkg::NUM_WHEELS-1:0] psi_nxt_unused;
    logic m1_bit_unused;
    logic m1_next_bit;
    logic m2_bit;
    logic m2_next_bit;
    logic m2_step;
    logic psi_step;

    // motor 1 steps with every character, motor 2 on motor 1's new bit, psi on motor 2's resulting bit
    assign m2_step  = i_step & m1_next_bit;
    assign psi_step = i_step & (m2_step ? m2_next_bit : m2_bit);

    ltc_wheel #(.LEN(ltc_pkg::CHI_LEN0), .PAT(ltc_pkg::CHI_PAT0)) u_chi0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(i_step),
        .o_bit(chi_bit[0]), .o_next_bit(chi_nxt_unused[0]));
    ltc_wheel #(.LEN(ltc_pkg::CHI_LEN1), .PAT(ltc_pkg::CHI_PAT1)) u_chi1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(i_step),
        .o_bit(chi_bit[1]), .o_next_bit(chi_nxt_unused[1]));
    ltc_wheel #(.LEN(ltc_pkg::CHI_LEN2), .PAT(ltc_pkg::CHI_PAT2)) u_chi2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(i_step),
        .o_bit(chi_bit[2]), .o_next_bit(chi_nxt_unused[2]));
    ltc_wheel #(.LEN(ltc_pkg::CHI_LEN3), .PAT(ltc_pkg::CHI_PAT3)) u_chi3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(i_step),
        .o_bit(chi_bit[3]), .o_next_bit(chi_nxt_unused[3]));
    ltc_wheel #(.LEN(ltc_pkg::CHI_LEN4), .PAT(ltc_pkg::CHI_PAT4)) u_chi4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(i_step),
        .o_bit(chi_bit[4]), .o_next_bit(chi_nxt_unused[4]));

    ltc_wheel #(.LEN(ltc_pkg::PSI_LEN0), .PAT(ltc_pkg::PSI_PAT0)) u_psi0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(psi_step),
        .o_bit(psi_bit[0]), .o_next_bit(psi_nxt_unused[0]));
    ltc_wheel #(.LEN(ltc_pkg::PSI_LEN1), .PAT(ltc_pkg::PSI_PAT1)) u_psi1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(psi_step),
        .o_bit(psi_bit[1]), .o_next_bit(psi_nxt_unused[1]));
    ltc_wheel #(.LEN(ltc_pkg::PSI_LEN2), .PAT(ltc_pkg::PSI_PAT2)) u_psi2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(psi_step),
        .o_bit(psi_bit[2]), .o_next_bit(psi_nxt_unused[2]));
    ltc_wheel #(.LEN(ltc_pkg::PSI_LEN3), .PAT(ltc_pkg::PSI_PAT3)) u_psi3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(psi_step),
        .o_bit(psi_bit[3]), .o_next_bit(psi_nxt_unused[3]));
    ltc_wheel #(.LEN(ltc_pkg::PSI_LEN4), .PAT(ltc_pkg::PSI_PAT4)) u_psi4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(psi_step),
        .o_bit(psi_bit[4]), .o_next_bit(psi_nxt_unused[4]));

    ltc_wheel #(.LEN(ltc_pkg::MOTOR1_LEN), .PAT(ltc_pkg::MOTOR1_PAT)) u_motor1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(i_step),
        .o_bit(m1_bit_unused), .o_next_bit(m1_next_bit));
    ltc_wheel #(.LEN(ltc_pkg::MOTOR2_LEN), .PAT(ltc_pkg::MOTOR2_PAT)) u_motor2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(m2_step),
        .o_bit(m2_bit), .o_next_bit(m2_next_bit));

    // first wheel pair forms the MSB
    always_comb begin
        for (int i = 0; i < ltc_pkg::NUM_WHEELS; i++) begin
            o_key[ltc_pkg::NUM_WHEELS-1-i] = chi_bit[i] ^ psi_bit[i];
        end
    end

endmodule

// ===== rtl/lorenz_teleprinter_cipher.sv =====
// Teleprinter cipher of the twelve-wheel type: one character byte in, one
// enciphered teleprinter code out.
// Input channel: i_s_tvalid / o_s_tready / i_s_tdata, one character byte per
// request. Output channel: o_m_tvalid / i_m_tready / o_m_tdata carrying the
// plain code, the key code and the cipher code of that character.
// The key is taken from the wheels as the request is accepted and the wheels
// advance in the same cycle, so results leave in the order requests came in.
// Pipeline: an accepted request is held in the input register, and its
// result is then computed into the result register that drives the output.
// Throughput: one character per cycle, sustained while the receiver keeps
// i_m_tready high.
// Reset: all wheels return to position zero and both stages empty.
// Stall: while the receiver holds i_m_tready low the result holds; one further
// request is taken into the input register, then o_s_tready falls until the
// output is taken.
`include "lorenz_teleprinter_cipher_macros.svh"

module lorenz_teleprinter_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [4:0] plain_code, [9:5] key_code,
                                     // [14:10] cipher_code, [15] zero
);

    logic             in_acc;
    logic             s2_adv;
    logic             s1_go;
    ltc_pkg::t_code   key;

    logic             r_s1_vld;
    ltc_pkg::t_char   r_s1_byte;
    ltc_pkg::t_code   r_s1_key;
    logic             r_out_vld;
    ltc_pkg::t_result r_out;
    ltc_pkg::t_result n_out;

    assign s2_adv     = !r_out_vld || i_m_tready;
    assign s1_go      = r_s1_vld && s2_adv;
    assign o_s_tready = !r_s1_vld || s2_adv;
    assign in_acc     = i_s_tvalid && o_s_tready;

    ltc_keystream u_keystream (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_acc),
        .o_key   (key)
    );

    always_comb begin
        n_out.plain_code  = ltc_pkg::code_of(r_s1_byte);
        n_out.key_code    = r_s1_key;
        n_out.cipher_code = n_out.plain_code ^ r_s1_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_s1_vld <= i_s_tvalid;
            end
            if (s2_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_byte <= i_s_tdata;
            r_s1_key  <= key;
        end
        if (s1_go) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_out};

    `LTC_ASSERT_NEXT(a_req_lands, in_acc, r_s1_vld)
    `LTC_ASSERT_NEXT(a_s1_held, r_s1_vld && !s2_adv,
        r_s1_vld && $stable(r_s1_key) && $stable(r_s1_byte))
    `LTC_ASSERT_NEXT(a_key_moves, s1_go, o_m_tvalid && (o_m_tdata[9:5] == $past(r_s1_key)))
    `LTC_ASSERT_SAME(a_cipher_xor, o_m_tvalid,
        o_m_tdata[14:10] == (o_m_tdata[4:0] ^ o_m_tdata[9:5]))

endmodule

// ===== dv/ltc_cipher_monitor.sv =====
module ltc_cipher_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [4:0] plain_code, [9:5] key_code,
                                     // [14:10] cipher_code, [15] zero
    output int          o_errors,
    output int          o_outstanding,
    output int          o_checked,
    output int          o_unmapped
);

    localparam int MAX_REPORTS = 10;

    localparam logic [0:40] CHI_WHEEL0 =
        41'b11111_00010_10110_00111_10001_01110_10001_00011_1;
    localparam logic [0:30] CHI_WHEEL1 =
        31'b11000_01101_01110_11010_11011_00100_0;
    localparam logic [0:28] CHI_WHEEL2 =
        29'b10001_00111_10011_00011_10111_1010;
    localparam logic [0:25] CHI_WHEEL3 =
        26'b11110_00110_10001_00011_10100_1;
    localparam logic [0:22] CHI_WHEEL4 =
        23'b11011_11000_00010_10001_110;
    localparam logic [0:42] PSI_WHEEL0 =
        43'b10110_00110_10010_10011_01010_10101_01101_01010_100;
    localparam logic [0:46] PSI_WHEEL1 =
        47'b11010_10101_01010_11101_10101_01010_11000_10101_01011_10;
    localparam logic [0:50] PSI_WHEEL2 =
        51'b10100_00100_11010_10101_01000_10110_10111_01010_10100_10100_1;
    localparam logic [0:52] PSI_WHEEL3 =
        53'b01010_11010_10100_00101_01001_10110_10100_11011_01011_01011_001;
    localparam logic [0:58] PSI_WHEEL4 =
        59'b01010_10101_01010_10110_10100_10011_01010_01001_01010_10010_00100_1010;
    localparam logic [0:60] MOTOR_WHEEL1 =
        61'b01011_11110_11010_11001_00011_10111_10001_00100_11100_01111_10101_11010_0;
    localparam logic [0:36] MOTOR_WHEEL2 =
        37'b01110_11100_01111_11111_00001_01011_11111_11;

    localparam int MOTOR1_SPAN = 61;
    localparam int MOTOR2_SPAN = 37;

    // codes of a..z, shared by the punctuation or digit alias of a letter where it has one
    localparam logic [5*26-1:0] LETTER_CODES = {
        5'd3, 5'd25, 5'd14, 5'd9, 5'd1, 5'd13, 5'd26, 5'd20, 5'd6, 5'd11,
        5'd15, 5'd18, 5'd28, 5'd12, 5'd24, 5'd22, 5'd23, 5'd10, 5'd5, 5'd16,
        5'd7, 5'd30, 5'd19, 5'd29, 5'd21, 5'd17
    };
    // letters with no alias hold their own letter, never reached by the search
    localparam logic [8*26-1:0] LETTER_ALIASES = "-?:d3!&h8j().,9014'57=2/6+";

    typedef struct packed {
        logic [7:0]      char_byte;
        ltc_pkg::t_result codes;
    } t_enciphered;

    logic [5:0]  chi_pos [5];
    logic [5:0]  psi_pos [5];
    logic [5:0]  motor1_pos;
    logic [5:0]  motor2_pos;
    t_enciphered expected_codes [$];
    int          errors;
    int          checked;
    int          unmapped;

    function automatic int chi_span(input int w);
        case (w)
            0: return 41;
            1: return 31;
            2: return 29;
            3: return 26;
            default: return 23;
        endcase
    endfunction

    function automatic int psi_span(input int w);
        case (w)
            0: return 43;
            1: return 47;
            2: return 51;
            3: return 53;
            default: return 59;
        endcase
    endfunction

    function automatic logic chi_bit(input int w, input logic [5:0] p);
        case (w)
            0: return CHI_WHEEL0[p];
            1: return CHI_WHEEL1[p];
            2: return CHI_WHEEL2[p];
            3: return CHI_WHEEL3[p];
            default: return CHI_WHEEL4[p];
        endcase
    endfunction

    function automatic logic psi_bit(input int w, input logic [5:0] p);
        case (w)
            0: return PSI_WHEEL0[p];
            1: return PSI_WHEEL1[p];
            2: return PSI_WHEEL2[p];
            3: return PSI_WHEEL3[p];
            default: return PSI_WHEEL4[p];
        endcase
    endfunction

    function automatic logic [5:0] step_wheel(input logic [5:0] p, input int span);
        return (int'(p) + 1 >= span) ? 6'd0 : p + 6'd1;
    endfunction

    function automatic ltc_pkg::t_code teleprinter_code(input logic [7:0] c);
        logic [7:0]     folded;
        ltc_pkg::t_code code;
        int             letter;
        int             i;
        folded = (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
        code = 5'd0;
        if (folded >= 8'h61 && folded <= 8'h7A) begin
            letter = int'(folded) - 'h61;
            code = LETTER_CODES[5*(25-letter) +: 5];
        end else if (c == 8'h20) begin
            code = 5'd4;
        end else if (c == 8'h0A) begin
            code = 5'd2;
        end else begin
            for (i = 0; i < 26; i++)
                if (LETTER_ALIASES[8*(25-i) +: 8] == c)
                    code = LETTER_CODES[5*(25-i) +: 5];
        end
        return code;
    endfunction

    // key from the current wheel positions, then advance the wheels
    function automatic t_enciphered encipher_char(input logic [7:0] c);
        t_enciphered    e;
        ltc_pkg::t_code key;
        int             w;
        key = '0;
        for (w = 0; w < 5; w++)
            key = {key[3:0], chi_bit(w, chi_pos[w]) ^ psi_bit(w, psi_pos[w])};
        for (w = 0; w < 5; w++)
            chi_pos[w] = step_wheel(chi_pos[w], chi_span(w));
        motor1_pos = step_wheel(motor1_pos, MOTOR1_SPAN);
        if (MOTOR_WHEEL1[motor1_pos])
            motor2_pos = step_wheel(motor2_pos, MOTOR2_SPAN);
        if (MOTOR_WHEEL2[motor2_pos])
            for (w = 0; w < 5; w++)
                psi_pos[w] = step_wheel(psi_pos[w], psi_span(w));
        e.char_byte         = c;
        e.codes.plain_code  = teleprinter_code(c);
        e.codes.key_code    = key;
        e.codes.cipher_code = e.codes.plain_code ^ key;
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_enciphered      want;
        ltc_pkg::t_result got;
        int               w;
        if (!i_rst_n) begin
            for (w = 0; w < 5; w++) begin
                chi_pos[w] = '0;
                psi_pos[w] = '0;
            end
            motor1_pos = '0;
            motor2_pos = '0;
            expected_codes.delete();
            errors   = 0;
            checked  = 0;
            unmapped = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[14:0];
                if (expected_codes.size() == 0) begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: result %04h with no request pending", $realtime,
                                 i_m_tdata);
                    errors++;
                end else begin
                    want = expected_codes.pop_front();
                    if (got.plain_code !== want.codes.plain_code
                            || got.key_code !== want.codes.key_code
                            || got.cipher_code !== want.codes.cipher_code
                            || i_m_tdata[15] !== 1'b0) begin
                        if (errors < MAX_REPORTS) begin
                            $display("%0t: result %0d char %02h: plain exp %0d got %0d,",
                                     $realtime, checked, want.char_byte,
                                     want.codes.plain_code, got.plain_code);
                            $display("    key exp %0d got %0d, cipher exp %0d got %0d, pad %b",
                                     want.codes.key_code, got.key_code,
                                     want.codes.cipher_code, got.cipher_code,
                                     i_m_tdata[15]);
                        end
                        errors++;
                    end
                    checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want = encipher_char(i_s_tdata);
                if (want.codes.plain_code == 5'd0)
                    unmapped++;
                expected_codes.push_back(want);
            end
        end
        o_errors      <= errors;
        o_outstanding <= expected_codes.size();
        o_checked     <= checked;
        o_unmapped    <= unmapped;
    end

endmodule

// ===== dv/lorenz_teleprinter_cipher_test.sv =====
module lorenz_teleprinter_cipher_test;

    localparam int RANDOM_CHARS = 700;
    localparam int CALM_TAIL    = 80;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_LEN    = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;    // [7:0] char_byte
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;    // [4:0] plain_code, [9:5] key_code,
                               // [14:10] cipher_code, [15] zero

    int  errors;
    int  outstanding;
    int  checked;
    int  unmapped;
    int  chars_sent;
    int  idle_pct;
    bit  calm;

    string text_pool =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 \n-?:!&().,'=/+";

    logic [7:0] directed_chars [25] = '{
        8'h00, 8'hFF, 8'h80, 8'h7F, 8'h20, 8'h0A, 8'h61, 8'h7A, 8'h41, 8'h5A,
        8'h2D, 8'h3F, 8'h2B, 8'h30, 8'h39, 8'h33, 8'h27, 8'h3D, 8'h2F, 8'h64,
        8'h40, 8'h5B, 8'h60, 8'h7B, 8'hC1
    };

    lorenz_teleprinter_cipher uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    ltc_cipher_monitor monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_unmapped    (unmapped)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return text_pool[$urandom_range(0, text_pool.len() - 1)];
        else if (r < 75)
            return 8'($urandom_range(0, 127));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // offer one character and hold it until taken
    task automatic send_char(input logic [7:0] c);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'($urandom);
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    initial begin
        int gap;
        bit held;
        held = 1'b0;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && chars_sent >= HOLD_AT) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
                gap = $urandom_range(1, 9);
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int i;
        chars_sent = 0;
        calm       = 1'b0;
        idle_pct   = 30;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 8'h00;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        foreach (directed_chars[k]) begin
            send_char(directed_chars[k]);
            maybe_pause();
        end

        for (i = 0; i < RANDOM_CHARS; i++) begin
            if (i % PHASE_LEN == 0)
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            if (i >= RANDOM_CHARS - CALM_TAIL)
                calm = 1'b1;
            send_char(pick_char());
            maybe_pause();
        end

        // drain
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Enciphered %0d characters (%0d directed, %0d unmapped); %0d results checked,",
                 chars_sent, $size(directed_chars), unmapped, checked);
        $display("with idle bursts on both sides and one long output stall; %0d mismatches.",
                 errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #200000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ltc_pkg.sv
rtl/ltc_wheel.sv
rtl/ltc_keystream.sv
rtl/lorenz_teleprinter_cipher.sv
dv/ltc_cipher_monitor.sv
dv/lorenz_teleprinter_cipher_test.sv
